// ===== hw/rtl/nmt2_pkg.sv =====
package nmt2_pkg;

  localparam int MaxMedoids = 16;
  localparam int DistW      = 40;
  localparam int IdxW       = 4;
  localparam int RootW      = 21;
  localparam int PaddrW     = 3;

  localparam logic [IdxW-1:0]  IdxTop  = '1;
  localparam logic [IdxW-1:0]  IdxCap  = (MaxMedoids - 1 > 15) ? IdxTop : IdxW'(MaxMedoids - 1);
  localparam logic [DistW-1:0] DistMax = '1;

  // register index, taken from paddr[2]
  localparam logic RegMetric = 1'b0;

  typedef enum logic [1:0] {
    MetManhattan = 2'd0,
    MetLinf      = 2'd1,
    MetEuclid    = 2'd2,
    MetGiven     = 2'd3
  } metric_e;

  typedef struct packed {
    logic signed [15:0] point_coord;
    logic signed [15:0] medoid_coord;
    logic [31:0]        given_distance;
    logic               last_dim;
    logic               last_medoid;
  } in_item_t;

  typedef struct packed {
    logic [DistW-1:0] best_distance;
    logic [DistW-1:0] second_distance;
    logic             second_valid;
    logic [IdxW-1:0]  best_medoid;
  } out_item_t;

  typedef struct packed {
    logic accum_en;
    logic rank_en;
    logic sqrt_start;
    logic sqrt_sel;    // 0: best, 1: second
    logic cap_best;
    logic cap_second;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic sqrt_done;
    logic out_free;
    logic euclid;
  } dp_sts_t;

endpackage

// ===== hw/rtl/nmt2_isqrt.sv =====
module nmt2_isqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [nmt2_pkg::DistW-1:0] value_i,
  output logic                       done_o,
  output logic [nmt2_pkg::RootW-1:0] root_o
);
  import nmt2_pkg::*;

  // bit-pair restoring square root, one result bit per cycle
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DistW:0]   rem_q, rem_d;
  logic [DistW:0]   res_q, res_d;
  logic [DistW:0]   bit_q, bit_d;
  logic [DistW+1:0] trial;

  always_comb begin
    trial  = {1'b0, res_q} + {1'b0, bit_q};
    busy_d = busy_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    res_d  = res_q;
    bit_d  = bit_q;
    if (start_i) begin
      busy_d = 1'b1;
      rem_d  = {1'b0, value_i};
      res_d  = '0;
      bit_d  = {1'b1, {DistW{1'b0}}};
    end else if (busy_q) begin
      if ({1'b0, rem_q} >= trial) begin
        rem_d = rem_q - trial[DistW:0];
        res_d = (res_q >> 1) + bit_q;
      end else begin
        res_d = res_q >> 1;
      end
      bit_d = bit_q >> 2;
      if (bit_q[0]) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    res_q <= res_d;
    bit_q <= bit_d;
  end

  assign done_o = done_q;
  assign root_o = res_q[RootW-1:0];

endmodule

// ===== hw/rtl/nmt2_dp.sv =====
module nmt2_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  nmt2_pkg::metric_e     metric_i,
  input  nmt2_pkg::in_item_t    in_data_i,
  input  nmt2_pkg::dp_cmd_t     cmd_i,
  output nmt2_pkg::dp_sts_t     sts_o,
  input  logic                  out_stall_i,
  output logic                  out_valid_o,
  output nmt2_pkg::out_item_t   out_data_o
);
  import nmt2_pkg::*;

  logic [DistW-1:0] dist_q, dist_d;
  logic [DistW-1:0] best_q, best_d;
  logic [DistW-1:0] second_q, second_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [IdxW-1:0]  cnt_q, cnt_d;
  logic [RootW-1:0] root_b_q, root_s_q;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q, out_d;

  logic signed [16:0] diff;
  logic [15:0]        abs_d;
  logic [31:0]        sq;
  logic [31:0]        addend;
  logic [DistW:0]     add_sum;
  logic [DistW-1:0]   sat_sum;
  logic [DistW-1:0]   term_next;
  logic               two;

  logic             sqrt_done;
  logic [RootW-1:0] root;

  nmt2_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.sqrt_start),
    .value_i (cmd_i.sqrt_sel ? second_q : best_q),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  always_comb begin
    diff    = {in_data_i.point_coord[15], in_data_i.point_coord}
            - {in_data_i.medoid_coord[15], in_data_i.medoid_coord};
    abs_d   = diff[16] ? 16'(-diff) : diff[15:0];
    sq      = abs_d * abs_d;
    addend  = (metric_i == MetEuclid) ? sq : 32'(abs_d);
    add_sum = {1'b0, dist_q} + (DistW + 1)'(addend);
    sat_sum = add_sum[DistW] ? DistMax : add_sum[DistW-1:0];
    case (metric_i)
      MetManhattan: term_next = sat_sum;
      MetLinf:      term_next = (DistW'(abs_d) > dist_q) ? DistW'(abs_d) : dist_q;
      MetEuclid:    term_next = sat_sum;
      MetGiven:     term_next = DistW'(in_data_i.given_distance);
      default:      term_next = dist_q;
    endcase
  end

  always_comb begin
    dist_d      = dist_q;
    best_d      = best_q;
    second_d    = second_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    two         = cnt_q >= IdxW'(2);

    if (cmd_i.accum_en) begin
      dist_d = term_next;
    end
    if (cmd_i.rank_en) begin
      if (dist_q < best_q) begin
        second_d = best_q;
        best_d   = dist_q;
        idx_d    = cnt_q;
      end else if (dist_q < second_q) begin
        second_d = dist_q;
      end
      if (cnt_q != IdxTop) begin
        cnt_d = cnt_q + 1'b1;
      end
      dist_d = '0;
    end
    if (cmd_i.emit) begin
      out_valid_d               = 1'b1;
      out_d.best_distance       = (metric_i == MetEuclid) ? DistW'(root_b_q) : best_q;
      out_d.second_distance     = !two ? DistMax
                                : (metric_i == MetEuclid) ? DistW'(root_s_q) : second_q;
      out_d.second_valid        = two;
      out_d.best_medoid         = (idx_q > IdxCap) ? IdxCap : idx_q;
      best_d                    = DistMax;
      second_d                  = DistMax;
      idx_d                     = '0;
      cnt_d                     = '0;
      dist_d                    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_q      <= '0;
      best_q      <= DistMax;
      second_q    <= DistMax;
      idx_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      dist_q      <= dist_d;
      best_q      <= best_d;
      second_q    <= second_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (cmd_i.cap_best) begin
      root_b_q <= root;
    end
    if (cmd_i.cap_second) begin
      root_s_q <= root;
    end
  end

  assign sts_o.sqrt_done = sqrt_done;
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;
  assign sts_o.euclid    = (metric_i == MetEuclid);
  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_q;

endmodule

// ===== hw/rtl/nmt2_ctrl.sv =====
module nmt2_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                last_dim_i,
  input  logic                last_medoid_i,
  output logic                in_stall_o,
  input  nmt2_pkg::dp_sts_t   sts_i,
  output nmt2_pkg::dp_cmd_t   cmd_o
);
  import nmt2_pkg::*;

  localparam logic [2:0] StRun  = 3'd0;
  localparam logic [2:0] StRank = 3'd1;
  localparam logic [2:0] StSqb  = 3'd2;
  localparam logic [2:0] StSqs  = 3'd3;
  localparam logic [2:0] StEmit = 3'd4;

  logic [2:0] state_q, state_d;
  logic       lmed_q, lmed_d;

  always_comb begin
    state_d = state_q;
    lmed_d  = lmed_q;
    cmd_o   = '0;
    case (state_q)
      StRun: begin
        if (in_valid_i) begin
          cmd_o.accum_en = 1'b1;
          if (last_dim_i) begin
            lmed_d  = last_medoid_i;
            state_d = StRank;
          end
        end
      end
      StRank: begin
        cmd_o.rank_en = 1'b1;
        if (!lmed_q) begin
          state_d = StRun;
        end else if (sts_i.euclid) begin
          // root is taken from the ranked sums, so the root unit starts in StSqb after ranking
          state_d = StSqb;
          cmd_o.sqrt_start = 1'b0;
        end else begin
          state_d = StEmit;
        end
      end
      StSqb: begin
        if (!sts_i.sqrt_done && lmed_q) begin
          cmd_o.sqrt_start = 1'b1;
          lmed_d           = 1'b0;
        end else if (sts_i.sqrt_done) begin
          cmd_o.cap_best   = 1'b1;
          cmd_o.sqrt_start = 1'b1;
          cmd_o.sqrt_sel   = 1'b1;
          state_d          = StSqs;
        end
      end
      StSqs: begin
        cmd_o.sqrt_sel = 1'b1;
        if (sts_i.sqrt_done) begin
          cmd_o.cap_second = 1'b1;
          state_d          = StEmit;
        end
      end
      StEmit: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = StRun;
        end
      end
      default: state_d = StRun;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StRun;
      lmed_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      lmed_q  <= lmed_d;
    end
  end

  assign in_stall_o = (state_q != StRun);

endmodule

// ===== hw/rtl/nearest_medoid_top2_core.sv =====
// Throughput: one item per cycle while a medoid's dimensions stream in.
// The last item of each medoid is followed by a ranking state (input stalled).
// At the point's end the result is registered from the emit state once the output
// is free; for Euclidean both roots come first (one iterative root unit, run twice).
// Reset (async, active low) clears the metric to Manhattan and the per-point state.
module nearest_medoid_top2_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  nmt2_pkg::in_item_t          in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output nmt2_pkg::out_item_t         out_data_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [nmt2_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import nmt2_pkg::*;

  metric_e metric_q;
  dp_cmd_t cmd;
  dp_sts_t sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      metric_q <= MetManhattan;
    end else if (psel && penable && pwrite && (paddr[2] == RegMetric)) begin
      metric_q <= metric_e'(pwdata[1:0]);
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegMetric) ? 32'(metric_q) : '0;

  nmt2_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .last_dim_i    (in_data_i.last_dim),
    .last_medoid_i (in_data_i.last_medoid),
    .in_stall_o    (in_stall_o),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  nmt2_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .metric_i    (metric_q),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== tb/nearest_medoid_top2_core_tb.sv =====
`timescale 1ns / 1ps

module nearest_medoid_top2_core_tb;
  import nmt2_pkg::*;

  localparam int CycleLimit   = 400000;
  localparam int SettleCycles = 60;
  localparam int HoldCycles   = 300;
  localparam int PhaseItems   = 220;
  localparam int FarDims      = 260;
  localparam logic [PaddrW-1:0] MetricAddr = {RegMetric, 2'b00};

  logic              clk;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  in_item_t          in_data_i   = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  out_item_t         out_data_o;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [PaddrW-1:0] paddr       = '0;
  logic [31:0]       pwdata      = '0;
  logic [31:0]       prdata;
  logic              pready;

  nearest_medoid_top2_core dut (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // predictor state for the point in progress
  metric_e          metric_now   = MetManhattan;
  logic [DistW-1:0] run_dist     = '0;
  logic [DistW-1:0] near_dist    = DistMax;
  logic [DistW-1:0] runner_dist  = DistMax;
  logic [IdxW-1:0]  near_idx     = '0;
  logic [IdxW-1:0]  medoids_seen = '0;

  out_item_t pending_top2[$];
  out_item_t want;

  int err_cnt    = 0;
  int cycles     = 0;
  int items_sent = 0;
  int burst_left = 0;
  int gap_max    = 0;
  int stall_pct  = 0;
  int hold_left  = 0;
  bit hold_req   = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("nearest_medoid_top2_core verification failed");
      $finish;
    end
  end

  // receiver: random stall pattern, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HoldCycles;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  function automatic logic [DistW-1:0] add_sat(logic [DistW-1:0] a, logic [DistW-1:0] b);
    logic [DistW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DistW] ? DistMax : s[DistW-1:0];
  endfunction

  // floor square root, two bits per step
  function automatic logic [DistW-1:0] floor_root(logic [DistW-1:0] v);
    logic [63:0] rem, res, probe;
    rem   = 64'(v);
    res   = '0;
    probe = 64'd1 << 40;
    while (probe > rem) probe >>= 2;
    while (probe != 0) begin
      if (rem >= res + probe) begin
        rem = rem - (res + probe);
        res = (res >> 1) + probe;
      end else begin
        res >>= 1;
      end
      probe >>= 2;
    end
    return res[DistW-1:0];
  endfunction

  task automatic rank_pair(in_item_t it);
    int               d;
    logic [DistW-1:0] ad, bd, sd;
    out_item_t        res;
    d  = int'(it.point_coord) - int'(it.medoid_coord);
    ad = DistW'(d < 0 ? -d : d);
    case (metric_now)
      MetManhattan: run_dist = add_sat(run_dist, ad);
      MetLinf:      if (ad > run_dist) run_dist = ad;
      MetEuclid:    run_dist = add_sat(run_dist, ad * ad);
      default:      run_dist = DistW'(it.given_distance);
    endcase
    if (!it.last_dim) return;
    // strict compare: ties keep the earlier medoid
    if (run_dist < near_dist) begin
      runner_dist = near_dist;
      near_dist   = run_dist;
      near_idx    = medoids_seen;
    end else if (run_dist < runner_dist) begin
      runner_dist = run_dist;
    end
    if (medoids_seen < IdxTop) medoids_seen++;
    run_dist = '0;
    if (!it.last_medoid) return;
    bd = near_dist;
    sd = runner_dist;
    if (metric_now == MetEuclid) begin
      bd = floor_root(bd);
      sd = floor_root(sd);
    end
    res.second_valid    = (medoids_seen >= 2);
    res.best_distance   = bd;
    res.second_distance = res.second_valid ? sd : DistMax;
    res.best_medoid     = (near_idx > IdxCap) ? IdxCap : near_idx;
    pending_top2.push_back(res);
    near_dist    = DistMax;
    runner_dist  = DistMax;
    near_idx     = '0;
    medoids_seen = '0;
  endtask

  task automatic check_field(string tag, logic [DistW-1:0] want_v, logic [DistW-1:0] got_v);
    if (want_v !== got_v) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, tag, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_top2.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result, expected none actual %h", $time, out_data_o);
      end else begin
        want = pending_top2.pop_front();
        check_field("best_distance", want.best_distance, out_data_o.best_distance);
        check_field("second_distance", want.second_distance, out_data_o.second_distance);
        check_field("second_valid", DistW'(want.second_valid), DistW'(out_data_o.second_valid));
        check_field("best_medoid", DistW'(want.best_medoid), DistW'(out_data_o.best_medoid));
      end
    end
  end

  function automatic in_item_t pair(int p, int m, logic [31:0] g, bit ld, bit lm);
    in_item_t it;
    it.point_coord    = 16'(p);
    it.medoid_coord   = 16'(m);
    it.given_distance = g;
    it.last_dim       = ld;
    it.last_medoid    = lm;
    return it;
  endfunction

  // kind 0: full range, 1: tiny values around zero (ties), 2: extremes
  function automatic logic signed [15:0] make_coord(int kind);
    case (kind)
      1:       return 16'(int'($urandom_range(0, 6)) - 3);
      2:       return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [31:0] make_given(int kind);
    case (kind)
      1:       return $urandom_range(0, 3);
      2:       return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_pair(in_item_t it);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (gap_max > 0) begin
        gap = $urandom_range(1, gap_max);
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk); while (in_stall_o);
    rank_pair(it);
    items_sent++;
  endtask

  task automatic send_point(int n_med, int dim_max, int kind);
    in_item_t it;
    int       n_dim;
    bit       mark_all;
    mark_all = $urandom_range(0, 1);
    for (int med = 0; med < n_med; med++) begin
      n_dim = $urandom_range(1, dim_max);
      for (int dim = 0; dim < n_dim; dim++) begin
        it.point_coord    = make_coord(kind);
        it.medoid_coord   = make_coord(kind);
        it.given_distance = make_given(kind);
        it.last_dim       = (dim == n_dim - 1);
        if (med == n_med - 1)
          it.last_medoid = mark_all || it.last_dim;
        else  // stray marker without last_dim is ignored by the block
          it.last_medoid = !it.last_dim && ($urandom_range(0, 19) == 0);
        send_pair(it);
      end
    end
  endtask

  // input idle until every result is back and the block has settled
  task automatic wait_quiet();
    @(negedge clk);
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending_top2.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic set_metric(metric_e m);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MetricAddr;
    pwdata  <= 32'(m);
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    check_field("metric readback", DistW'(m), DistW'(prdata[1:0]));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    metric_now = m;
  endtask

  // full-scale differences under every metric; first pass runs on the reset metric
  task automatic test_extremes();
    for (int i = 0; i < 4; i++) begin
      if (i > 0) begin
        wait_quiet();
        set_metric(metric_e'(i));
      end
      send_pair(pair(-32768, 32767, 32'hFFFF_FFFF, 1'b1, 1'b0));
      send_pair(pair(32767, -32768, 32'h0, 1'b1, 1'b1));
    end
  endtask

  task automatic test_ties();
    wait_quiet();
    set_metric(MetManhattan);
    send_pair(pair(5, 0, 0, 1'b1, 1'b0));
    send_pair(pair(0, 5, 0, 1'b1, 1'b0));
    send_pair(pair(-2, 3, 0, 1'b1, 1'b1));
  endtask

  // one medoid only, with last_medoid raised before its last dimension
  task automatic test_lone_medoid();
    wait_quiet();
    set_metric(MetLinf);
    send_pair(pair(100, -7, 0, 1'b0, 1'b1));
    send_pair(pair(-3, 4, 0, 1'b0, 1'b0));
    send_pair(pair(0, 0, 0, 1'b1, 1'b1));
  endtask

  // first medoid ranked under Manhattan, last under Euclid; root applies to both
  task automatic test_metric_switch();
    wait_quiet();
    set_metric(MetManhattan);
    send_pair(pair(300, 0, 0, 1'b0, 1'b0));
    send_pair(pair(0, 200, 0, 1'b1, 1'b0));
    wait_quiet();
    set_metric(MetEuclid);
    send_pair(pair(1000, 0, 0, 1'b1, 1'b1));
  endtask

  task automatic test_backpressure();
    wait_quiet();
    set_metric(MetManhattan);
    gap_max   = 0;
    stall_pct = 0;
    hold_req  = 1'b1;
    for (int i = 0; i < 40; i++) send_point(1, 1, 0);
    wait_quiet();
  endtask

  task automatic test_random_phase(metric_e m, int gmax, int spct, bit with_far);
    int start_cnt;
    wait_quiet();
    set_metric(m);
    gap_max   = gmax;
    stall_pct = spct;
    start_cnt = items_sent;
    if (with_far) begin
      // enough full-scale squares to saturate the 40-bit sum
      for (int i = 0; i < FarDims; i++)
        send_pair(pair(32767, -32768, 0, i == FarDims - 1, 1'b0));
      send_point(1, 2, 0);
    end
    while (items_sent - start_cnt < PhaseItems)
      send_point(($urandom_range(0, 9) == 0) ? $urandom_range(15, 20) : $urandom_range(1, 6),
                 ($urandom_range(0, 19) == 0) ? 12 : 3,
                 ($urandom_range(0, 19) < 10) ? 0 : (($urandom_range(0, 9) < 7) ? 1 : 2));
  endtask

  initial begin
    gap_max   = 2;
    stall_pct = 30;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    test_extremes();
    test_ties();
    test_lone_medoid();
    test_metric_switch();
    test_backpressure();

    test_random_phase(MetManhattan, 4, 30, 1'b0);
    test_random_phase(MetLinf,      0,  0, 1'b0);
    test_random_phase(MetEuclid,    3, 20, 1'b1);
    test_random_phase(MetGiven,     6, 50, 1'b0);
    test_random_phase(MetManhattan, 0, 60, 1'b0);
    test_random_phase(MetEuclid,    2,  0, 1'b0);
    test_random_phase(MetGiven,     0, 25, 1'b0);
    test_random_phase(MetLinf,      8, 40, 1'b0);

    wait_quiet();
    repeat (SettleCycles) @(posedge clk);
    if (err_cnt == 0) begin
      $display("nearest_medoid_top2_core verification clean");
    end else begin
      $display("nearest_medoid_top2_core verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/nmt2_pkg.sv
hw/rtl/nmt2_isqrt.sv
hw/rtl/nmt2_dp.sv
hw/rtl/nmt2_ctrl.sv
hw/rtl/nearest_medoid_top2_core.sv
tb/nearest_medoid_top2_core_tb.sv
